// File: design/akf_pkg.sv
// Package: widths, constants, sequencer states and shared types for the altitude Kalman filter.
package akf_pkg;

   localparam int DataWidth = 32;
   localparam int DtWidth   = 16;
   localparam int AddrWidth = 1;

   localparam logic [AddrWidth-1:0] RegAccelNoise = 1'd0;
   localparam logic [AddrWidth-1:0] RegBaroNoise  = 1'd1;

   localparam logic [DataWidth-1:0] AccelNoiseReset = 32'd65536;
   localparam logic [DataWidth-1:0] BaroNoiseReset  = 32'd65536;
   localparam logic signed [DataWidth-1:0] QOne     = 32'sd65536;
   localparam logic signed [DataWidth-1:0] QHalf    = 32'sd32768;
   localparam logic signed [DataWidth-1:0] QQuarter = 32'sd16384;

   // Gain divide: 50-bit dividend, restoring, one quotient bit per cycle.
   localparam int DivBits = 50;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_DT2, ST_DT3, ST_DT4,
      ST_VDT, ST_ADT2, ST_ADT2H, ST_ALT, ST_ADT, ST_VEL,
      ST_DT4Q, ST_Q00, ST_DT3H, ST_Q01, ST_Q11,
      ST_PSUM, ST_P11DT2, ST_P11DT, ST_COVP,
      ST_DIV0, ST_DIV1,
      ST_UPD0, ST_UPD1, ST_UPD2, ST_UPD3, ST_UPD4, ST_UPD5,
      ST_OUT
   } state_type;

   // Q16.16 product: 34x32 signed, floor by 2^16, saturate to 32 bits.
   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [66:0] v);
      if (v > 67'sd2147483647)        return 32'sh7fffffff;
      else if (v < -67'sd2147483648)  return 32'sh80000000;
      else                            return v[DataWidth-1:0];
   endfunction

endpackage

// File: design/altitude_kalman_filter.sv
// Top level: two-state altitude/velocity Kalman filter on one shared multiplier and divider.
// Each transaction runs through a sequencer that drives one 34x32 multiplier and one
// serial divider: 18 predict and covariance steps, two gain divisions, 6 update steps,
// a load of the result register and a return to idle to accept the next transaction.
// A zero innovation variance skips both divisions. req_stall is high from accept until the
// result is loaded; a result held by rsp_stall delays the next item only when that item's
// result is ready. Config writes are accepted at any time but must only be issued while idle.
module altitude_kalman_filter
   import akf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [DataWidth-1:0] req_accel_vertical,
   input  logic signed [DataWidth-1:0] req_baro_altitude,
   input  logic [DtWidth-1:0]          req_time_step,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DataWidth-1:0] rsp_altitude_estimate,
   output logic signed [DataWidth-1:0] rsp_velocity_estimate,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [AddrWidth-1:0]        csr_index,
   input  logic [DataWidth-1:0]        csr_data
);

   typedef logic signed [DataWidth-1:0] q_type;

   state_type state_ff, state_in;
   logic [DataWidth-1:0] accel_noise_ff, baro_noise_ff;
   q_type alt_ff, vel_ff, pp_ff, pv_ff, vp_ff, vv_ff;
   q_type alt_in, vel_in, pp_in, pv_in, vp_in, vv_in;
   q_type a_ff, z_ff, dt_ff;
   q_type dt2_ff, dt3_ff, dt4_ff, t0_ff, t1_ff, t2_ff, k0_ff, k1_ff, y_ff;
   q_type dt2_in, dt3_in, dt4_in, t0_in, t1_in, t2_in, k0_in, k1_in, y_in;
   logic signed [33:0] psum_ff, psum_in;
   logic signed [33:0] s_ff, s_in;
   logic rsp_valid_ff, rsp_valid_in;
   q_type rsp_alt_ff, rsp_alt_in, rsp_vel_ff, rsp_vel_in;

   // shared multiplier
   logic signed [33:0] mul_a;
   q_type mul_b;
   logic signed [66:0] mul_p;
   q_type mul_q;
   assign mul_p = mul_a * mul_b;
   assign mul_q = sat32(mul_p >>> 16);

   // serial divider (magnitudes)
   logic [5:0] div_cnt_ff, div_cnt_in;
   logic [DivBits-1:0] div_rem_ff, div_rem_in, div_quo_ff, div_quo_in;
   logic [DivBits-1:0] div_num_ff, div_num_in;
   logic div_neg_ff, div_neg_in;
   logic [DivBits-1:0] div_den, div_trial;
   logic [DivBits-1:0] div_sh;
   logic signed [DivBits:0] div_qs;
   q_type div_res;

   assign div_den = s_ff[33] ? DivBits'(-s_ff) : DivBits'(s_ff);
   assign div_sh  = {div_rem_ff[DivBits-2:0], div_num_ff[DivBits-1]};
   assign div_trial = div_sh - div_den;
   assign div_qs  = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
   assign div_res = sat32(67'(div_qs));

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_altitude_estimate = rsp_alt_ff;
   assign rsp_velocity_estimate = rsp_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_alt_ff     <= '0;
         rsp_vel_ff     <= '0;
         accel_noise_ff <= AccelNoiseReset;
         baro_noise_ff  <= BaroNoiseReset;
         alt_ff <= '0; vel_ff <= '0; pp_ff <= QOne; pv_ff <= '0; vp_ff <= '0; vv_ff <= QOne;
         div_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_alt_ff   <= rsp_alt_in;
         rsp_vel_ff   <= rsp_vel_in;
         if (csr_valid && csr_index == RegAccelNoise) accel_noise_ff <= csr_data;
         if (csr_valid && csr_index == RegBaroNoise)  baro_noise_ff  <= csr_data;
         alt_ff <= alt_in; vel_ff <= vel_in; pp_ff <= pp_in;
         pv_ff <= pv_in; vp_ff <= vp_in; vv_ff <= vv_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         a_ff  <= req_accel_vertical;
         z_ff  <= req_baro_altitude;
         dt_ff <= q_type'({16'd0, req_time_step});
      end
      dt2_ff <= dt2_in; dt3_ff <= dt3_in; dt4_ff <= dt4_in;
      t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in;
      k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      psum_ff <= psum_in; s_ff <= s_in;
      div_rem_ff <= div_rem_in; div_quo_ff <= div_quo_in;
      div_num_ff <= div_num_in; div_neg_ff <= div_neg_in;
   end

   // starts a gain division of num*65536 by s
   function automatic logic [DivBits-1:0] div_mag(input q_type num);
      logic signed [DivBits-1:0] w;
      w = DivBits'(num) <<< 16;
      return w[DivBits-1] ? -w : w;
   endfunction

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_alt_in = rsp_alt_ff; rsp_vel_in = rsp_vel_ff;
      alt_in = alt_ff; vel_in = vel_ff; pp_in = pp_ff;
      pv_in = pv_ff; vp_in = vp_ff; vv_in = vv_ff;
      dt2_in = dt2_ff; dt3_in = dt3_ff; dt4_in = dt4_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff;
      k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff;
      psum_in = psum_ff; s_in = s_ff;
      div_cnt_in = div_cnt_ff; div_rem_in = div_rem_ff; div_quo_in = div_quo_ff;
      div_num_in = div_num_ff; div_neg_in = div_neg_ff;
      mul_a = 34'(dt_ff);
      mul_b = dt_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DT2;
         ST_DT2:    begin dt2_in = mul_q; state_in = ST_DT3; end
         ST_DT3:    begin mul_a = 34'(dt2_ff); dt3_in = mul_q; state_in = ST_DT4; end
         ST_DT4:    begin mul_a = 34'(dt2_ff); mul_b = dt2_ff; dt4_in = mul_q;
                          state_in = ST_VDT; end
         ST_VDT:    begin mul_a = 34'(vel_ff); t0_in = mul_q; state_in = ST_ADT2; end
         ST_ADT2:   begin mul_a = 34'(a_ff); mul_b = dt2_ff; t1_in = mul_q;
                          state_in = ST_ADT2H; end
         ST_ADT2H:  begin mul_a = 34'(t1_ff); mul_b = QHalf; t1_in = mul_q;
                          state_in = ST_ALT; end
         ST_ALT:    begin
                       alt_in = sat32(67'(alt_ff) + 67'(t0_ff) + 67'(t1_ff));
                       state_in = ST_ADT;
                    end
         ST_ADT:    begin mul_a = 34'(a_ff); t0_in = mul_q; state_in = ST_VEL; end
         ST_VEL:    begin vel_in = sat32(67'(vel_ff) + 67'(t0_ff)); state_in = ST_DT4Q; end
         ST_DT4Q:   begin mul_a = 34'(dt4_ff); mul_b = QQuarter; t0_in = mul_q;
                          state_in = ST_Q00; end
         ST_Q00:    begin mul_a = 34'({1'b0, accel_noise_ff}); mul_b = t0_ff; t0_in = mul_q;
                          state_in = ST_DT3H; end
         ST_DT3H:   begin mul_a = 34'(dt3_ff); mul_b = QHalf; t1_in = mul_q;
                          state_in = ST_Q01; end
         ST_Q01:    begin mul_a = 34'({1'b0, accel_noise_ff}); mul_b = t1_ff; t1_in = mul_q;
                          state_in = ST_Q11; end
         ST_Q11:    begin mul_a = 34'({1'b0, accel_noise_ff}); mul_b = dt2_ff; t2_in = mul_q;
                          psum_in = 34'(vp_ff) + 34'(pv_ff); state_in = ST_PSUM; end
         ST_PSUM:   begin mul_a = psum_ff; y_in = mul_q; state_in = ST_P11DT2; end
         ST_P11DT2: begin mul_a = 34'(dt2_ff); mul_b = vv_ff; k0_in = mul_q;
                          state_in = ST_P11DT; end
         ST_P11DT:  begin mul_a = 34'(vv_ff); k1_in = mul_q; state_in = ST_COVP; end
         ST_COVP:   begin
                       pp_in = sat32(67'(pp_ff) + 67'(y_ff) + 67'(k0_ff) + 67'(t0_ff));
                       pv_in = sat32(67'(pv_ff) + 67'(k1_ff) + 67'(t1_ff));
                       vp_in = sat32(67'(vp_ff) + 67'(k1_ff) + 67'(t1_ff));
                       vv_in = sat32(67'(vv_ff) + 67'(t2_ff));
                       y_in  = sat32(67'(z_ff) - 67'(alt_ff));
                       s_in  = 34'(pp_in) + 34'({1'b0, baro_noise_ff});
                       div_num_in = div_mag(pp_in);
                       div_neg_in = pp_in[DataWidth-1] ^ s_in[33];
                       div_rem_in = '0; div_quo_in = '0; div_cnt_in = '0;
                       state_in = ST_DIV0;
                    end
         ST_DIV0, ST_DIV1: begin
            if (s_ff == '0) begin
               k0_in = '0; k1_in = '0; state_in = ST_UPD0;
            end else if (div_cnt_ff == 6'(DivBits)) begin
               div_num_in = div_mag(vp_ff);
               div_neg_in = vp_ff[DataWidth-1] ^ s_ff[33];
               div_rem_in = '0; div_quo_in = '0; div_cnt_in = '0;
               if (state_ff == ST_DIV0) begin
                  k0_in = div_res; state_in = ST_DIV1;
               end else begin
                  k1_in = div_res; state_in = ST_UPD0;
               end
            end else begin
               div_num_in = div_num_ff << 1;
               div_cnt_in = div_cnt_ff + 6'd1;
               if (!div_trial[DivBits-1] && div_sh >= div_den) begin
                  div_rem_in = div_trial; div_quo_in = {div_quo_ff[DivBits-2:0], 1'b1};
               end else begin
                  div_rem_in = div_sh; div_quo_in = {div_quo_ff[DivBits-2:0], 1'b0};
               end
            end
         end
         ST_UPD0:   begin mul_a = 34'(k0_ff); mul_b = y_ff; t0_in = mul_q; state_in = ST_UPD1; end
         ST_UPD1:   begin mul_a = 34'(k1_ff); mul_b = y_ff; t1_in = mul_q;
                          alt_in = sat32(67'(alt_ff) + 67'(t0_ff)); state_in = ST_UPD2; end
         ST_UPD2:   begin mul_a = 34'(k0_ff); mul_b = pp_ff; t0_in = mul_q;
                          vel_in = sat32(67'(vel_ff) + 67'(t1_ff)); state_in = ST_UPD3; end
         ST_UPD3:   begin mul_a = 34'(k0_ff); mul_b = pv_ff; t1_in = mul_q; state_in = ST_UPD4; end
         ST_UPD4:   begin mul_a = 34'(k1_ff); mul_b = pp_ff; t2_in = mul_q; state_in = ST_UPD5; end
         ST_UPD5:   begin
                       mul_a = 34'(k1_ff); mul_b = pv_ff;
                       pp_in = sat32(67'(pp_ff) - 67'(t0_ff));
                       pv_in = sat32(67'(pv_ff) - 67'(t1_ff));
                       vp_in = sat32(67'(vp_ff) - 67'(t2_ff));
                       vv_in = sat32(67'(vv_ff) - 67'(mul_q));
                       state_in = ST_OUT;
                    end
         // load the result register once the previous transaction has left it
         ST_OUT:    begin
                       if (!rsp_valid_ff || !rsp_stall) begin
                          rsp_alt_in = alt_ff;
                          rsp_vel_in = vel_ff;
                          rsp_valid_in = 1'b1;
                          state_in = ST_IDLE;
                       end
                    end
         default:   state_in = ST_IDLE;
      endcase
   end

endmodule
